/* src/frag_pkg.sv */
// shared types and constants for the fragment reassembler
package frag_pkg;

  localparam int unsigned WORDS_PER_SLOT = 16;

  localparam logic [2:0] ST_NOT_ADDR  = 3'd0;
  localparam logic [2:0] ST_STORED    = 3'd1;
  localparam logic [2:0] ST_SEQ_ERR   = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_HALTED    = 3'd4;
  localparam logic [2:0] ST_MSG_WORD  = 3'd5;
  localparam logic [2:0] ST_RELEASED  = 3'd6;

  localparam logic KIND_FRAME   = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  localparam logic [7:0] END_MARKER = 8'hFF;

  localparam logic [0:0] REG_LOCAL_ADDRESS = 1'd0;

  // queued word between front and back
  typedef struct packed {
    logic        kind;
    logic [28:0] frame_id;
    logic [63:0] payload;
    logic [5:0]  slot_index;
  } frag_req_t;

endpackage

/* src/frag_if.sv */
// valid/ready channel interfaces for input and result words
interface frag_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [28:0] frame_id;
  logic [63:0] payload;
  logic [5:0]  slot_index;
  modport source (output valid, kind, frame_id, payload, slot_index, input ready);
  modport sink (input valid, kind, frame_id, payload, slot_index, output ready);
endinterface

interface frag_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [11:0] source_address;
  logic [5:0]  slot;
  logic [63:0] message_word;
  logic [3:0]  word_number;
  logic [7:0]  message_length;
  logic        last;
  modport source (output valid, status, source_address, slot, message_word, word_number,
                  message_length, last, input ready);
  modport sink (input valid, status, source_address, slot, message_word, word_number,
                message_length, last, output ready);
endinterface

/* src/frag_front.sv */
// input word queue: accepts words and buffers them for the engine
module frag_front import frag_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  frag_in_if.sink    in_ch,
  output logic       req_valid,
  input  logic       req_ready,
  output frag_req_t  req
);

  frag_req_t  q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push = in_ch.valid && in_ch.ready;
  assign pop  = req_valid && req_ready;
  assign req_valid = (cnt_r != 2'd0);
  assign req = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= '{kind: in_ch.kind, frame_id: in_ch.frame_id,
                     payload: in_ch.payload, slot_index: in_ch.slot_index};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

/* src/frag_back.sv */
// reassembly engine: slot search, sequence check, fragment store, message readout
module frag_back import frag_pkg::*; #(
  parameter int unsigned NODE_SLOTS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [11:0] local_address,
  input  logic        req_valid,
  output logic        req_ready,
  input  frag_req_t   req,
  frag_out_if.source  out_ch
);

  localparam int unsigned SW = (NODE_SLOTS > 1) ? $clog2(NODE_SLOTS) : 1;
  localparam int unsigned CW = $clog2(NODE_SLOTS + 1);
  localparam int unsigned AW = SW + 4;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SEARCH = 3'd1;
  localparam logic [2:0] S_CHECK  = 3'd2;
  localparam logic [2:0] S_READ   = 3'd3;
  localparam logic [2:0] S_EMIT   = 3'd4;
  localparam logic [2:0] S_OUT    = 3'd5;

  logic [2:0]  state_r;
  frag_req_t   cur_r;
  logic [CW-1:0] idx_r;
  logic        have_free_r;
  logic [SW-1:0] free_r, slot_r;
  logic [3:0]  wnum_r;
  logic [3:0]  nmark_r;
  logic        halted_r;

  logic [NODE_SLOTS-1:0] in_use_r;
  logic [11:0] src_mem [NODE_SLOTS];
  logic [4:0]  exp_mem [NODE_SLOTS];
  logic [63:0] store_mem [NODE_SLOTS*WORDS_PER_SLOT];
  logic [11:0] src_rd_r;
  logic [4:0]  exp_rd_r;
  logic [63:0] store_rd_r;

  // output register
  logic        ov_r;
  logic [2:0]  ost_r;
  logic [11:0] osrc_r;
  logic [5:0]  oslot_r;
  logic [63:0] oword_r;
  logic [3:0]  onum_r;
  logic [7:0]  olen_r;
  logic        olast_r;

  logic [11:0] src, dest;
  logic [3:0]  seq;
  logic        addressed;
  logic [SW-1:0] idx_s;
  logic        out_free;
  logic [3:0]  first_ff;
  logic        has_ff;

  // slot allocated on this frame: expected sequence taken as zero
  logic alloc_r;

  assign src  = cur_r.frame_id[15:4];
  assign dest = cur_r.frame_id[27:16];
  assign seq  = cur_r.frame_id[3:0];
  assign addressed = (dest == local_address) || (cur_r.frame_id[28] && dest == 12'd0);
  assign idx_s = idx_r[SW-1:0];
  assign out_free = !ov_r || out_ch.ready;
  assign req_ready = (state_r == S_IDLE);

  always_comb begin
    first_ff = 4'd8;
    for (int b = 7; b >= 0; b--) begin
      if (cur_r.payload[8*b +: 8] == END_MARKER) first_ff = 4'(b);
    end
    has_ff = (first_ff != 4'd8);
  end

  // registered reads of slot tables and fragment store
  always_ff @(posedge clk) begin
    src_rd_r <= src_mem[idx_s];
    exp_rd_r <= exp_mem[slot_r];
    store_rd_r <= store_mem[{slot_r, wnum_r}];
  end

  logic src_wr, exp_wr, st_wr;
  logic [4:0] exp_wdata;
  logic [AW-1:0] st_waddr;
  assign st_waddr = {slot_r, seq};
  always_ff @(posedge clk) begin
    if (src_wr) src_mem[slot_r] <= src;
    if (exp_wr) exp_mem[slot_r] <= exp_wdata;
    if (st_wr) store_mem[st_waddr] <= cur_r.payload;
  end

  // search step pending flag: slot table reads are registered
  logic srch_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      in_use_r <= '0;
      halted_r <= 1'b0;
      ov_r <= 1'b0;
      srch_v_r <= 1'b0;
    end else begin
      if (ov_r && out_ch.ready) ov_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (req_valid) begin
            cur_r <= req;
            state_r <= S_SEARCH;
            // a release reads its slot directly, a frame scans from slot 0
            idx_r <= (req.kind == KIND_RELEASE) ? CW'(req.slot_index) : '0;
            have_free_r <= 1'b0;
            srch_v_r <= 1'b0;
          end
        end
        S_SEARCH: begin
          if (cur_r.kind == KIND_RELEASE) begin
            if (!srch_v_r) begin
              srch_v_r <= 1'b1;
            end else if (out_free) begin
              ov_r <= 1'b1; ost_r <= ST_RELEASED; oslot_r <= cur_r.slot_index;
              oword_r <= '0; onum_r <= '0; olen_r <= '0; olast_r <= 1'b1;
              if ({26'd0, cur_r.slot_index} < 32'(NODE_SLOTS) && in_use_r[idx_s]) begin
                osrc_r <= src_rd_r;
                in_use_r[idx_s] <= 1'b0;
              end else begin
                osrc_r <= '0;
              end
              state_r <= S_IDLE;
            end
          end else if (halted_r || !addressed) begin
            if (out_free) begin
              ov_r <= 1'b1; ost_r <= halted_r ? ST_HALTED : ST_NOT_ADDR; osrc_r <= src;
              oslot_r <= '0; oword_r <= '0; onum_r <= '0; olen_r <= '0; olast_r <= 1'b1;
              state_r <= S_IDLE;
            end
          end else begin
            // read of idx_r issued this cycle; examine previous index
            srch_v_r <= 1'b1;
            if (srch_v_r) begin
              if (in_use_r[free_r] && src_rd_r == src) begin
                slot_r <= free_r;
                state_r <= S_CHECK;
                srch_v_r <= 1'b0;
              end else begin
                if (!have_free_r && !in_use_r[free_r]) begin
                  have_free_r <= 1'b1;
                  slot_r <= free_r;
                end
                if (32'(free_r) == NODE_SLOTS - 1) begin
                  srch_v_r <= 1'b0;
                  if (!have_free_r && in_use_r[free_r]) begin
                    halted_r <= 1'b1;
                    state_r <= S_OUT;
                  end else begin
                    // allocate new slot; expected sequence becomes zero
                    in_use_r[have_free_r ? slot_r : free_r] <= 1'b1;
                    if (!have_free_r) slot_r <= free_r;
                    state_r <= S_CHECK;
                    have_free_r <= 1'b1; // sets the free-slot flag; new allocation is marked by alloc_r
                  end
                end
              end
            end
            free_r <= idx_s;
            if (idx_r != CW'(NODE_SLOTS - 1)) idx_r <= idx_r + 1'b1;
          end
        end
        S_OUT: begin
          if (out_free) begin
            ov_r <= 1'b1; ost_r <= ST_FULL; osrc_r <= src; oslot_r <= '0;
            oword_r <= '0; onum_r <= '0; olen_r <= '0; olast_r <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        S_CHECK: begin
          // first issues expected-seq read, then evaluates
          if (!srch_v_r) begin
            srch_v_r <= 1'b1;
          end else if (out_free) begin
            srch_v_r <= 1'b0;
            osrc_r <= src; oslot_r <= 6'(slot_r); oword_r <= '0; onum_r <= '0;
            olen_r <= '0; olast_r <= 1'b1;
            if ((alloc_r ? 5'd0 : exp_rd_r) != {1'b0, seq}) begin
              ov_r <= 1'b1; ost_r <= ST_SEQ_ERR; state_r <= S_IDLE;
            end else if (!has_ff) begin
              ov_r <= 1'b1; ost_r <= ST_STORED; state_r <= S_IDLE;
            end else begin
              nmark_r <= first_ff;
              wnum_r <= '0;
              state_r <= S_READ;
            end
          end
        end
        S_READ: begin
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            ov_r <= 1'b1; ost_r <= ST_MSG_WORD; osrc_r <= src; oslot_r <= 6'(slot_r);
            oword_r <= store_rd_r; onum_r <= wnum_r;
            olen_r <= {1'b0, seq, 3'd0} + {4'd0, nmark_r} + 8'd1;
            olast_r <= (wnum_r == seq);
            if (wnum_r == seq) begin
              state_r <= S_IDLE;
            end else begin
              wnum_r <= wnum_r + 4'd1;
              state_r <= S_READ;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alloc_r <= 1'b0;
    end else if (state_r == S_IDLE) begin
      alloc_r <= 1'b0;
    end else if (state_r == S_SEARCH && srch_v_r && cur_r.kind == KIND_FRAME && addressed
                 && !halted_r && 32'(free_r) == NODE_SLOTS - 1
                 && !(in_use_r[free_r] && src_rd_r == src)
                 && (have_free_r || !in_use_r[free_r])) begin
      alloc_r <= 1'b1;
    end
  end

  always_comb begin
    src_wr = 1'b0; exp_wr = 1'b0; st_wr = 1'b0; exp_wdata = '0;
    if (state_r == S_CHECK && srch_v_r && out_free) begin
      if (alloc_r) src_wr = 1'b1;
      if ((alloc_r ? 5'd0 : exp_rd_r) == {1'b0, seq}) begin
        st_wr = 1'b1;
        exp_wr = 1'b1;
        exp_wdata = has_ff ? 5'd0 : 5'({1'b0, seq} + 5'd1);
      end else if (alloc_r) begin
        exp_wr = 1'b1;
      end
    end
  end

  assign out_ch.valid = ov_r;
  assign out_ch.status = ost_r;
  assign out_ch.source_address = osrc_r;
  assign out_ch.slot = oslot_r;
  assign out_ch.message_word = oword_r;
  assign out_ch.word_number = onum_r;
  assign out_ch.message_length = olen_r;
  assign out_ch.last = olast_r;

endmodule

/* src/fragment_reassembler.sv */
// fragment reassembler top level: config register, input queue, reassembly engine
// a frame's slot is found by a linear search of the slot table, one slot table read per
// cycle; releases read their slot directly and dropped frames skip the search; message
// words are read back from the fragment store one at a time, each read then emitted
// the engine takes one word at a time; a two-entry queue takes words meanwhile
// reset (rst_n low, synchronous) frees all slots, clears the halt, local address 1
module fragment_reassembler import frag_pkg::*; #(
  parameter int unsigned NODE_SLOTS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  frag_in_if.sink     in_ch,
  frag_out_if.source  out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [11:0] local_address_r;
  logic        req_valid, req_ready;
  frag_req_t   req;

  assign cfg_pready = 1'b1;
  // register index sits at the word address bit
  assign cfg_prdata = (cfg_paddr[2] == REG_LOCAL_ADDRESS) ? {20'd0, local_address_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_address_r <= 12'd1;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[2] == REG_LOCAL_ADDRESS) begin
      local_address_r <= cfg_pwdata[11:0];
    end
  end

  frag_front u_front (
    .clk, .rst_n, .in_ch, .req_valid, .req_ready, .req
  );

  frag_back #(.NODE_SLOTS(NODE_SLOTS)) u_back (
    .clk, .rst_n, .local_address(local_address_r), .req_valid, .req_ready, .req, .out_ch
  );

endmodule

/* sim/tb_top.sv */
// testbench for the fragment reassembler: random and directed frames checked against a predictor
`timescale 1ns / 1ps

module tb_top;
  import frag_pkg::*;

  localparam int SLOTS = 64;
  localparam int SETTLE = SLOTS + 60;      // engine latency with margin
  localparam int LIMIT = 2000000;          // cycle limit for the whole run

  typedef struct {
    logic [2:0]  status;
    logic [11:0] source_address;
    logic [5:0]  slot;
    logic [63:0] message_word;
    logic [3:0]  word_number;
    logic [7:0]  message_length;
    logic        last;
  } frag_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [2:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  frag_in_if in_ch ();
  frag_out_if out_ch ();

  fragment_reassembler #(.NODE_SLOTS(SLOTS)) dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #5 clk = ~clk;

  // words waiting to be sent, and results the engine owes us
  frag_req_t pending_words[$];
  frag_res_t owed_results[$];

  int fails = 0;
  int words_sent = 0;
  int results_seen = 0;
  int messages_seen = 0;
  int cycles = 0;

  // shadow copy of the reassembly state
  logic [11:0] shadow_local = 12'd1;
  logic        shadow_used[SLOTS];
  logic [11:0] shadow_src[SLOTS];
  logic [4:0]  shadow_seq[SLOTS];
  logic [63:0] shadow_store[SLOTS][WORDS_PER_SLOT];
  logic        shadow_halted = 1'b0;

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      shadow_used[i] = 1'b0;
      shadow_src[i] = '0;
      shadow_seq[i] = '0;
    end
  end

  // idle profile: mostly short gaps, a few long ones, with quiet stretches
  int in_calm = 0;
  int out_calm = 0;

  function automatic int pick_gap(ref int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(199) == 0) calm = 60;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic void owe(logic [2:0] st, logic [11:0] src, logic [5:0] slot,
                              logic [63:0] w, logic [3:0] wn, logic [7:0] len, logic last);
    frag_res_t r;
    r.status = st;
    r.source_address = src;
    r.slot = slot;
    r.message_word = w;
    r.word_number = wn;
    r.message_length = len;
    r.last = last;
    owed_results.push_back(r);
  endfunction

  // work out the results one accepted word causes and update the shadow state
  function automatic void reassemble(frag_req_t q);
    logic        bcast;
    logic [11:0] dest, src;
    logic [3:0]  seq;
    int found, free_slot, n;
    bcast = q.frame_id[28];
    dest = q.frame_id[27:16];
    src = q.frame_id[15:4];
    seq = q.frame_id[3:0];
    found = -1;
    free_slot = -1;
    if (q.kind == KIND_RELEASE) begin
      if (shadow_used[q.slot_index]) begin
        owe(ST_RELEASED, shadow_src[q.slot_index], q.slot_index, '0, '0, '0, 1'b1);
        shadow_used[q.slot_index] = 1'b0;
      end else begin
        owe(ST_RELEASED, '0, q.slot_index, '0, '0, '0, 1'b1);
      end
      return;
    end
    if (shadow_halted) begin
      owe(ST_HALTED, src, '0, '0, '0, '0, 1'b1);
      return;
    end
    if (!(dest == shadow_local || (bcast && dest == '0))) begin
      owe(ST_NOT_ADDR, src, '0, '0, '0, '0, 1'b1);
      return;
    end
    // linear search: first matching source wins, remember first free slot on the way
    for (int i = 0; i < SLOTS; i++) begin
      if (shadow_used[i] && shadow_src[i] == src) begin
        found = i;
        break;
      end
      if (free_slot < 0 && !shadow_used[i]) free_slot = i;
    end
    if (found < 0) begin
      if (free_slot < 0) begin
        shadow_halted = 1'b1;
        owe(ST_FULL, src, '0, '0, '0, '0, 1'b1);
        return;
      end
      found = free_slot;
      shadow_used[found] = 1'b1;
      shadow_src[found] = src;
      shadow_seq[found] = '0;
    end
    if (shadow_seq[found] != {1'b0, seq}) begin
      owe(ST_SEQ_ERR, src, found[5:0], '0, '0, '0, 1'b1);
      return;
    end
    shadow_store[found][seq] = q.payload;
    n = 8;
    for (int b = 0; b < 8; b++) begin
      if (q.payload[8*b +: 8] == END_MARKER) begin
        n = b;
        break;
      end
    end
    if (n == 8) begin
      shadow_seq[found] = shadow_seq[found] + 5'd1;
      owe(ST_STORED, src, found[5:0], '0, '0, '0, 1'b1);
      return;
    end
    // end marker seen: whole message goes out, sequence restarts
    shadow_seq[found] = '0;
    for (int w = 0; w <= seq; w++)
      owe(ST_MSG_WORD, src, found[5:0], shadow_store[found][w], w[3:0],
          8'(seq * 8 + n + 1), (w == seq));
  endfunction

  // input driver: one nonblocking write of valid per edge
  int in_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.kind <= KIND_FRAME;
      in_ch.frame_id <= '0;
      in_ch.payload <= '0;
      in_ch.slot_index <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        reassemble(pending_words.pop_front());
        words_sent++;
        in_gap = pick_gap(in_calm);
      end
      if (in_ch.valid && !in_ch.ready) begin
        // hold the word until taken
      end else if (in_gap > 0) begin
        in_gap--;
        in_ch.valid <= 1'b0;
      end else if (pending_words.size() > 0) begin
        in_ch.valid <= 1'b1;
        in_ch.kind <= pending_words[0].kind;
        in_ch.frame_id <= pending_words[0].frame_id;
        in_ch.payload <= pending_words[0].payload;
        in_ch.slot_index <= pending_words[0].slot_index;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  task automatic report(string field, logic [63:0] got, logic [63:0] want);
    fails++;
    $display("mismatch on result %0d: %s got %0h want %0h", results_seen, field, got, want);
  endtask

  // result monitor with random back-pressure
  int out_stall = 0;
  always @(posedge clk) begin
    frag_res_t w;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (owed_results.size() == 0) begin
          report("unexpected result status", {61'd0, out_ch.status}, '0);
        end else begin
          w = owed_results.pop_front();
          if (out_ch.status !== w.status) report("status", out_ch.status, w.status);
          if (out_ch.source_address !== w.source_address)
            report("source_address", out_ch.source_address, w.source_address);
          if (out_ch.slot !== w.slot) report("slot", out_ch.slot, w.slot);
          if (out_ch.message_word !== w.message_word)
            report("message_word", out_ch.message_word, w.message_word);
          if (out_ch.word_number !== w.word_number)
            report("word_number", out_ch.word_number, w.word_number);
          if (out_ch.message_length !== w.message_length)
            report("message_length", out_ch.message_length, w.message_length);
          if (out_ch.last !== w.last) report("last", out_ch.last, w.last);
          if (w.status == ST_MSG_WORD && w.last) messages_seen++;
        end
        results_seen++;
      end
      if (out_stall > 0) begin
        out_stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if ($urandom_range(3) == 0) out_stall = pick_gap(out_calm);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // stimulus helpers
  function automatic logic [63:0] no_marker(logic [63:0] x);
    for (int b = 0; b < 8; b++)
      if (x[8*b +: 8] == END_MARKER) x[8*b +: 8] = 8'hFE;
    return x;
  endfunction

  function automatic logic [63:0] rand_word();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] with_marker(logic [63:0] x);
    int n;
    n = $urandom_range(7);
    x = no_marker(x);
    x[8*n +: 8] = END_MARKER;
    return x;
  endfunction

  task automatic push_frame(logic bcast, logic [11:0] dest, logic [11:0] src,
                            logic [3:0] seq, logic [63:0] payload);
    frag_req_t q;
    q.kind = KIND_FRAME;
    q.frame_id = {bcast, dest, src, seq};
    q.payload = payload;
    q.slot_index = 6'($urandom());
    pending_words.push_back(q);
  endtask

  task automatic push_release(logic [5:0] idx);
    frag_req_t q;
    q.kind = KIND_RELEASE;
    q.frame_id = 29'($urandom());
    q.payload = rand_word();
    q.slot_index = idx;
    pending_words.push_back(q);
  endtask

  task automatic wait_idle();
    while (pending_words.size() > 0 || owed_results.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // register write over the cfg port; setup then access phase
  task automatic write_local(logic [11:0] value);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= 3'(4 * REG_LOCAL_ADDRESS);
    cfg_pwdata <= {$urandom_range(1) ? 20'hFFFFF : 20'h0, value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    shadow_local = value;
  endtask

  // a message from one source: mostly well formed, sometimes a fragment lost or repeated
  task automatic push_message(logic [11:0] src, int frags);
    logic bcast;
    logic [11:0] dest;
    if ($urandom_range(3) == 0) begin
      bcast = 1'b1;
      dest = '0;
    end else begin
      bcast = 1'($urandom());
      dest = shadow_local;
    end
    for (int s = 0; s < frags; s++) begin
      if ($urandom_range(29) == 0) continue;
      if (s == frags - 1) push_frame(bcast, dest, src, s[3:0], with_marker(rand_word()));
      else push_frame(bcast, dest, src, s[3:0], no_marker(rand_word()));
      if ($urandom_range(29) == 0) push_frame(bcast, dest, src, s[3:0], rand_word());
    end
  endtask

  task automatic random_phase(int count);
    logic [11:0] pool[8];
    int issued, frags;
    for (int i = 0; i < 8; i++) pool[i] = 12'($urandom());
    pool[0] = 12'h000;
    pool[1] = 12'hFFF;
    issued = 0;
    while (issued < count) begin
      if ($urandom_range(99) < 75) begin
        frags = ($urandom_range(32) == 0) ? 16 : $urandom_range(4, 1);
        push_message(pool[$urandom_range(7)], frags);
        issued += frags;
      end else if ($urandom_range(1) == 0) begin
        push_release(6'($urandom()));
        issued++;
      end else begin
        push_frame(1'($urandom()), 12'($urandom()), pool[$urandom_range(7)],
                   4'($urandom()), rand_word());
        issued++;
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part at the reset address
    push_frame(1'b0, 12'd5, 12'h0AB, 4'd0, '0);                  // other destination
    push_frame(1'b1, 12'd0, 12'h0AB, 4'd0, '1);                  // broadcast, all marker bytes
    push_frame(1'b0, 12'd1, 12'hFFF, 4'd0, '0);                  // first of two
    push_frame(1'b0, 12'd1, 12'hFFF, 4'd1, 64'h1234_5678_9AFF_CDEF); // bytes after marker
    push_frame(1'b0, 12'd1, 12'h123, 4'd3, rand_word());         // new source, wrong sequence
    push_frame(1'b0, 12'd0, 12'h321, 4'd0, '0);                  // zero without broadcast bit
    push_frame(1'b1, 12'd1, 12'h321, 4'd0, 64'h0000_0000_0000_FF00);
    push_release(6'd2);
    push_release(6'd63);                                         // free slot
    // sequence runs past fifteen, then locks up the source
    for (int s = 0; s < 16; s++) push_frame(1'b0, 12'd1, 12'h456, s[3:0], no_marker(rand_word()));
    push_frame(1'b0, 12'd1, 12'h456, 4'd0, '1);
    wait_idle();

    write_local(12'd0);
    random_phase(70);
    wait_idle();
    write_local(12'hFFF);
    random_phase(70);
    wait_idle();
    write_local(12'($urandom()));
    random_phase(80);
    wait_idle();
    write_local(12'd1);
    random_phase(30);
    wait_idle();

    // fill the table then overflow it; reception stays halted, releases still answer
    for (int i = 0; i < SLOTS; i++) push_release(i[5:0]);
    for (int i = 0; i < SLOTS; i++)
      push_frame(1'b0, shadow_local, 12'h800 + 12'(i), 4'd0, no_marker(rand_word()));
    push_frame(1'b0, shadow_local, 12'h900, 4'd0, '1);
    push_frame(1'b0, shadow_local, 12'h800, 4'd1, '1);
    push_frame(1'b1, 12'd0, 12'h901, 4'd0, rand_word());
    push_release(6'd5);
    push_frame(1'b0, shadow_local, 12'h902, 4'd0, '1);
    push_release(6'd5);
    wait_idle();

    $display("sent %0d words, checked %0d results, %0d full messages", words_sent,
             results_seen, messages_seen);
    $display("covered four local addresses, broadcast, sequence errors, table overflow");
    if (fails == 0 && owed_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
